/* rtl/sha_pkg.sv */
`default_nettype none
package sha_pkg;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  typedef struct packed {
    logic       load_byte;
    logic       shift_word;
    logic [7:0] byte_in;
  } sched_ctl_t;

  typedef struct packed {
    logic init;
    logic round;
    logic add;
    logic rotate;
    logic restart;
  } core_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* rtl/sha_sched.sv */
`default_nettype none
module sha_sched (
  input  wire logic              clk,
  input  wire sha_pkg::sched_ctl_t ctl,
  output logic [31:0]            w
);
  import sha_pkg::*;

  logic [511:0] window;
  logic [31:0]  w1;
  logic [31:0]  w14;
  logic [31:0]  s0;
  logic [31:0]  s1;
  logic [31:0]  w_new;

  assign w   = window[511:480];
  assign w1  = window[479:448];
  assign w14 = window[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w + s0 + window[223:192] + s1;

  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      window <= {window[503:0], ctl.byte_in};
    end else if (ctl.shift_word) begin
      window <= {window[479:0], w_new};
    end
  end

endmodule
`default_nettype wire

/* rtl/sha_core.sv */
`default_nettype none
module sha_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha_pkg::core_ctl_t ctl,
  input  wire logic [31:0]        w,
  input  wire logic [31:0]        k,
  output logic [31:0]             h_out
);
  import sha_pkg::*;

  logic [31:0] hw [8];
  logic [31:0] v  [8];
  logic [31:0] big0;
  logic [31:0] big1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign h_out = hw[0];
  assign big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + big1 + ch + k + w;
  assign big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = big0 + maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      hw <= HASH_INIT;
    end else if (ctl.restart) begin
      hw <= HASH_INIT;
    end else if (ctl.add) begin
      for (int i = 0; i < 8; i++) begin
        hw[i] <= hw[i] + v[i];
      end
    end else if (ctl.rotate) begin
      for (int i = 0; i < 7; i++) begin
        hw[i] <= hw[i + 1];
      end
      hw[7] <= hw[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      v <= hw;
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

/* rtl/sha256_byte_stream_hasher_core.sv */
// SHA-256 hasher that takes the message one byte per input word (tuser low) and a finish
// command (tuser high), after which it pads the message, appends the 64-bit bit length and
// returns the digest as eight 32-bit big-endian words, index in tuser, tlast on the eighth.
// Each data byte is shifted into the block; the 64th byte of a block then runs the block
// through one shared round unit for all 64 rounds and then folds the result into the hash
// words. A finish feeds the pad and length bytes one per cycle up to the end of the block
// (a second block when 56 or more bytes are pending), runs the rounds and the fold for each
// block, then offers the eight digest words. The input is not ready while any of that work
// is in progress.
`default_nettype none
module sha256_byte_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // digest_word
  output logic [2:0]       m_axis_tuser,  // word_index
  output logic             m_axis_tlast
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [63:0] bits;
  logic [5:0]  rnd;
  logic [2:0]  idx;
  logic        fin;
  logic        first;
  logic        len_ok;
  logic        last_blk;
  logic        in_fire;
  logic        out_fire;
  logic [7:0]  pad_byte;
  logic [31:0] w;
  logic [31:0] h_out;
  sched_ctl_t  sctl;
  core_ctl_t   cctl;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = h_out;
  assign m_axis_tuser  = idx;
  assign m_axis_tlast  = (idx == LAST_WORD);

  always_comb begin
    if (first) begin
      pad_byte = PAD_MARK;
    end else if (len_ok && cnt >= LEN_POS) begin
      pad_byte = bits[{~cnt[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    sctl.load_byte  = (in_fire && !s_axis_tuser) || (state == S_PAD);
    sctl.byte_in    = (state == S_PAD) ? pad_byte : s_axis_tdata;
    sctl.shift_word = (state == S_ROUND);
    cctl.init    = sctl.load_byte && (cnt == LAST_BYTE);
    cctl.round   = (state == S_ROUND);
    cctl.add     = (state == S_ADD);
    cctl.rotate  = out_fire;
    cctl.restart = out_fire && (idx == LAST_WORD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      bits     <= '0;
      rnd      <= '0;
      idx      <= '0;
      fin      <= 1'b0;
      first    <= 1'b0;
      len_ok   <= 1'b0;
      last_blk <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser) begin
              fin    <= 1'b1;
              first  <= 1'b1;
              len_ok <= (cnt < LEN_POS);
              state  <= S_PAD;
            end else begin
              cnt  <= cnt + 6'd1;
              bits <= bits + 64'd8;
              if (cnt == LAST_BYTE) begin
                rnd   <= '0;
                state <= S_ROUND;
              end
            end
          end
        end
        S_PAD: begin
          first <= 1'b0;
          cnt   <= cnt + 6'd1;
          if (cnt == LAST_BYTE) begin
            last_blk <= len_ok;
            len_ok   <= 1'b1;
            rnd      <= '0;
            state    <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (!fin) begin
            state <= S_IDLE;
          end else if (last_blk) begin
            idx   <= '0;
            state <= S_OUT;
          end else begin
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            idx <= idx + 3'd1;
            if (idx == LAST_WORD) begin
              bits  <= '0;
              fin   <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  sha_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .w   (w)
  );

  sha_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cctl),
    .w     (w),
    .k     (ROUND_K[rnd]),
    .h_out (h_out)
  );

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == LAST_ROUND) |=> (state == S_ADD))
    else $error("round counter did not hand over to the hash update");

  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (cnt == 6'd0 && fin))
    else $error("digest offered with bytes still pending");

  a_pad_in_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD) |-> fin)
    else $error("padding outside a finish");

  a_digest_done: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_axis_tlast) |=> (state == S_IDLE && bits == 64'd0))
    else $error("message state not restarted after the last digest word");

endmodule
`default_nettype wire
